// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Shared sizes, status codes, state encoding and the block table entry type.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
	localparam int HEADER_BYTES = 16;
	localparam int SIZE_W       = 20;
	localparam int TOP_W        = 21;
	localparam int STATUS_W     = 3;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic [TOP_W-1:0] LIMIT_CAP   = TOP_W'(1048576);
	localparam logic [TOP_W-1:0] LIMIT_RESET = TOP_W'(65536);

	// Register word indexes on the configuration port.
	localparam logic REG_HEAP_LIMIT = 1'b0;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_HEAP_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd4;

	// Request kinds (only the low bit of kind is meaningful).
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_APPEND = 5'b00100,
		S_FREE   = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	typedef struct packed {
		logic              free;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] start;
	} entry_t;

endpackage

// ----- rtl/ffba_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit block allocator
// Keeps a table of heap blocks in address order and serves allocate and
// free requests, one transaction at a time, against a block table in RAM.
// ----------------------------------------------------------------------------
// The block table (start offset, payload size and free mark of each block)
// lives in a single RAM with a registered read port; the block count, the
// heap top and the heap limit register are flip-flops. An allocate request
// reads the table entries one per cycle from index zero until a free block
// fits or the table ends. A free request with a valid handle reads its entry
// once; a zero-size allocate or a bad handle goes straight to its result. A
// result still stalled in the output register holds the next one back. The
// next request can be accepted from the cycle in which the result is
// presented. The table needs no clearing pass after reset: only entries
// below the block count are ever used, and each of them was written when it
// was appended. A result sits in an output register, so a new request is
// taken while the previous result is still stalled on the response channel.
// heap_limit may only be written while no transaction is in flight; values
// above 1 MiB behave as 1 MiB.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                kind,
	input  logic [ffba_pkg::SIZE_W-1:0]         req_size,
	input  logic [ffba_pkg::IDX_W-1:0]          block_handle,
	// Response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [ffba_pkg::STATUS_W-1:0]       status,
	output logic [ffba_pkg::IDX_W-1:0]          handle,
	output logic [ffba_pkg::SIZE_W-1:0]         payload_offset,
	output logic [ffba_pkg::SIZE_W-1:0]         block_bytes,
	output logic [ffba_pkg::TOP_W-1:0]          heap_used,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ffba_pkg::PADDR_W-1:0]        paddr,
	input  logic [ffba_pkg::PDATA_W-1:0]        pwdata,
	output logic [ffba_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	import ffba_pkg::*;

	// Control state.
	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOP_W-1:0]   heap_top_q;
	logic [TOP_W-1:0]   heap_limit_q;
	logic [CNT_W-1:0]   issue_q;
	logic               rd_vld_s1;
	logic               out_valid_q;

	// Request and result payload registers.
	logic [SIZE_W-1:0]   size_q;
	logic [IDX_W-1:0]    hdl_q;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_handle_q;
	logic [SIZE_W-1:0]   res_offset_q;
	logic [SIZE_W-1:0]   res_bytes_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [IDX_W-1:0]    out_handle_q;
	logic [SIZE_W-1:0]   out_offset_q;
	logic [SIZE_W-1:0]   out_bytes_q;
	logic [TOP_W-1:0]    out_heap_q;

	// RAM port signals.
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	entry_t             ram_rdata;

	logic               req_acc;
	logic               out_free;
	logic               cfg_wr;
	logic [TOP_W-1:0]   limit_eff;
	logic [TOP_W:0]     new_top;
	logic               scan_hit;
	logic               free_is_top;

	ffba_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Requests are taken only while idle; the response side has its own
	// register, so a stalled result does not hold up acceptance of the next request.
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_HEAP_LIMIT) ?
	                {{(PDATA_W-TOP_W){1'b0}}, heap_limit_q} : '0;

	assign limit_eff = (heap_limit_q > LIMIT_CAP) ? LIMIT_CAP : heap_limit_q;

	// Heap top after an append: old top plus header plus payload.
	assign new_top = {1'b0, heap_top_q} + (TOP_W+1)'(size_q) + (TOP_W+1)'(HEADER_BYTES);

	// During the scan the entry read in the previous cycle is checked here.
	assign scan_hit = rd_vld_s1 && ram_rdata.free && (ram_rdata.size >= size_q);

	// The freed block is the last one in the table when its index is count-1.
	assign free_is_top = ((CNT_W'(hdl_q) + CNT_W'(1)) == count_q);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = issue_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					ram_re    = 1'b1;
					ram_raddr = (kind == KIND_FREE) ? block_handle : '0;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					ram_we         = 1'b1;
					ram_wdata.free = 1'b0;
				end else if (issue_q < count_q) begin
					ram_re = 1'b1;
				end
			end
			S_APPEND: begin
				if ((new_top <= {1'b0, limit_eff}) && (count_q < CNT_W'(MAX_BLOCKS))) begin
					ram_we          = 1'b1;
					ram_waddr       = count_q[IDX_W-1:0];
					ram_wdata.free  = 1'b0;
					ram_wdata.size  = size_q;
					ram_wdata.start = heap_top_q[SIZE_W-1:0];
				end
			end
			S_FREE: begin
				if (!free_is_top) begin
					ram_we         = 1'b1;
					ram_waddr      = hdl_q;
					ram_wdata.free = 1'b1;
				end
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			heap_top_q   <= '0;
			heap_limit_q <= LIMIT_RESET;
			issue_q      <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_HEAP_LIMIT)) begin
				heap_limit_q <= pwdata[TOP_W-1:0];
			end
			// The output register is loaded as the result leaves S_RESP and
			// emptied when the response transaction completes.
			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (kind == KIND_FREE) begin
							state_q <= (CNT_W'(block_handle) < count_q) ? S_FREE : S_RESP;
						end else if (req_size == '0) begin
							state_q <= S_RESP;
						end else if (count_q == '0) begin
							state_q <= S_APPEND;
						end else begin
							state_q   <= S_SCAN;
							issue_q   <= CNT_W'(1);
							rd_vld_s1 <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q   <= S_RESP;
						rd_vld_s1 <= 1'b0;
					end else if (issue_q < count_q) begin
						issue_q   <= issue_q + CNT_W'(1);
						rd_vld_s1 <= 1'b1;
					end else begin
						state_q   <= S_APPEND;
						rd_vld_s1 <= 1'b0;
					end
				end
				S_APPEND: begin
					state_q <= S_RESP;
					if ((new_top <= {1'b0, limit_eff}) && (count_q < CNT_W'(MAX_BLOCKS))) begin
						count_q    <= count_q + CNT_W'(1);
						heap_top_q <= new_top[TOP_W-1:0];
					end
				end
				S_FREE: begin
					state_q <= S_RESP;
					if (free_is_top) begin
						count_q    <= CNT_W'(hdl_q);
						heap_top_q <= TOP_W'(ram_rdata.start);
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture, result assembly and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					size_q       <= req_size;
					hdl_q        <= block_handle;
					rd_idx_s1    <= '0;
					res_offset_q <= '0;
					res_bytes_q  <= '0;
					if (kind == KIND_FREE) begin
						res_status_q <= ST_BAD_HANDLE;
						res_handle_q <= block_handle;
					end else begin
						res_status_q <= ST_ZERO;
						res_handle_q <= '0;
					end
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					res_status_q <= ST_OK;
					res_handle_q <= rd_idx_s1;
					res_offset_q <= ram_rdata.start + SIZE_W'(HEADER_BYTES);
					res_bytes_q  <= ram_rdata.size;
				end else begin
					rd_idx_s1 <= issue_q[IDX_W-1:0];
				end
			end
			S_APPEND: begin
				if (new_top > {1'b0, limit_eff}) begin
					res_status_q <= ST_HEAP_FULL;
				end else if (count_q >= CNT_W'(MAX_BLOCKS)) begin
					res_status_q <= ST_TABLE_FULL;
				end else begin
					res_status_q <= ST_OK;
					res_handle_q <= count_q[IDX_W-1:0];
					res_offset_q <= heap_top_q[SIZE_W-1:0] + SIZE_W'(HEADER_BYTES);
					res_bytes_q  <= size_q;
				end
			end
			S_FREE: begin
				res_status_q <= ST_OK;
				res_handle_q <= hdl_q;
				res_offset_q <= ram_rdata.start + SIZE_W'(HEADER_BYTES);
				res_bytes_q  <= ram_rdata.size;
			end
			S_RESP: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_handle_q <= res_handle_q;
					out_offset_q <= res_offset_q;
					out_bytes_q  <= res_bytes_q;
					out_heap_q   <= heap_top_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid      = out_valid_q;
	assign status         = out_status_q;
	assign handle         = out_handle_q;
	assign payload_offset = out_offset_q;
	assign block_bytes    = out_bytes_q;
	assign heap_used      = out_heap_q;

endmodule

// ----- rtl/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// First-fit block allocator port checker
// Watches the top-level ports and flags responses or handshakes that the
// allocator must never produce.
// ----------------------------------------------------------------------------
module ffba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [ffba_pkg::STATUS_W-1:0] status,
	input logic [ffba_pkg::SIZE_W-1:0]   payload_offset,
	input logic [ffba_pkg::SIZE_W-1:0]   block_bytes,
	input logic [ffba_pkg::TOP_W-1:0]    heap_used
);

	import ffba_pkg::*;

	// A stalled response stays presented.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response withdrawn while stalled");

	// Only one transaction is in flight: an accepted request closes the door.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in flight");

	// A failed request describes no block.
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_OK) |-> (payload_offset == '0) && (block_bytes == '0))
		else $error("failed response carries block fields");

	// A successful response points past a block header.
	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_OK) |-> (payload_offset >= SIZE_W'(HEADER_BYTES)))
		else $error("payload offset lies inside the first header");

	// The heap never grows past the hard cap.
	a_heap_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (heap_used <= LIMIT_CAP))
		else $error("heap top beyond the cap");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req_valid),
	.req_stall      (req_stall),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.status         (status),
	.payload_offset (payload_offset),
	.block_bytes    (block_bytes),
	.heap_used      (heap_used)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Drives allocate and free requests with random idle and stall bursts, keeps
// its own mirror of the block table to predict every result, and checks each
// response transaction field by field. It also writes and reads back the heap
// limit register between phases of the run.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import ffba_pkg::*;

	// Two mirrors of the block table are kept. The checking mirror advances on
	// each request transaction the block accepts; the steering mirror advances
	// as requests are queued, so that the stimulus can aim its frees at blocks
	// that exist. Both see the same requests in the same order.
	localparam int CHECK_COPY = 0;
	localparam int STEER_COPY = 1;

	// An allocate may walk the whole table before answering.
	localparam int SETTLE_CYCLES = MAX_BLOCKS + 16;
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct packed {
		logic              kind;
		logic [SIZE_W-1:0] size;
		logic [IDX_W-1:0]  hnd;
	} alloc_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    handle;
		logic [SIZE_W-1:0]   offset;
		logic [SIZE_W-1:0]   bytes;
		logic [TOP_W-1:0]    used;
	} alloc_rsp_t;

	typedef enum {SZ_TINY, SZ_MID, SZ_BIG} size_mix_t;

	// Clock, reset and the ports of the block. Every input starts at a known
	// value so that nothing floats before the first falling edge.
	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                req_valid      = 1'b0;
	logic                req_stall;
	logic                kind           = KIND_ALLOC;
	logic [SIZE_W-1:0]   req_size       = '0;
	logic [IDX_W-1:0]    block_handle   = '0;
	logic                rsp_valid;
	logic                rsp_stall      = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    handle;
	logic [SIZE_W-1:0]   payload_offset;
	logic [SIZE_W-1:0]   block_bytes;
	logic [TOP_W-1:0]    heap_used;
	logic                psel           = 1'b0;
	logic                penable        = 1'b0;
	logic                pwrite         = 1'b0;
	logic [PADDR_W-1:0]  paddr          = '0;
	logic [PDATA_W-1:0]  pwdata         = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Mirror of the block table, block count, heap top and heap limit.
	entry_t              blk_tab[2][MAX_BLOCKS];
	logic [CNT_W-1:0]    blk_count[2];
	logic [TOP_W-1:0]    blk_top[2];
	logic [TOP_W-1:0]    limit_bytes;

	alloc_req_t          pending_requests[$];
	alloc_rsp_t          expected_results[$];

	int                  mismatch_count = 0;
	int                  cycle_count    = 0;
	int                  send_gap       = 0;
	int                  stall_left     = 0;
	bit                  steady_tail    = 1'b0;
	bit                  req_fire       = 1'b0;
	alloc_req_t          next_req;
	alloc_rsp_t          want;

	first_fit_block_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.kind           (kind),
		.req_size       (req_size),
		.block_handle   (block_handle),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.handle         (handle),
		.payload_offset (payload_offset),
		.block_bytes    (block_bytes),
		.heap_used      (heap_used),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #4ns clk = ~clk;

	// Works out the result of one request against the given mirror and updates
	// that mirror as the block would.
	function automatic alloc_rsp_t serve_request(int copy, alloc_req_t rq);
		alloc_rsp_t       rsp;
		logic [TOP_W-1:0] cap;
		int unsigned      need;
		int unsigned      slot;
		bit               placed;
		rsp = '0;
		placed = 1'b0;
		if (rq.kind == KIND_ALLOC) begin
			if (rq.size == '0) begin
				rsp.status = ST_ZERO;
			end else begin
				// First fit: the lowest-indexed free block that is large enough is
				// reused as it stands, without splitting.
				for (int i = 0; i < int'(blk_count[copy]); i++) begin
					if (!placed && blk_tab[copy][i].free && blk_tab[copy][i].size >= rq.size) begin
						placed = 1'b1;
						blk_tab[copy][i].free = 1'b0;
						rsp.status = ST_OK;
						rsp.handle = IDX_W'(i);
						rsp.offset = blk_tab[copy][i].start + SIZE_W'(HEADER_BYTES);
						rsp.bytes  = blk_tab[copy][i].size;
					end
				end
				if (!placed) begin
					// No free block fits, so a new one goes on at the heap top. The
					// heap check is made before the table check.
					cap  = (limit_bytes > LIMIT_CAP) ? LIMIT_CAP : limit_bytes;
					need = 32'(blk_top[copy]) + 32'(HEADER_BYTES) + 32'(rq.size);
					if (need > 32'(cap)) begin
						rsp.status = ST_HEAP_FULL;
					end else if (blk_count[copy] >= MAX_BLOCKS) begin
						rsp.status = ST_TABLE_FULL;
					end else begin
						slot = 32'(blk_count[copy]);
						blk_tab[copy][slot].free  = 1'b0;
						blk_tab[copy][slot].size  = rq.size;
						blk_tab[copy][slot].start = SIZE_W'(blk_top[copy]);
						blk_count[copy] = blk_count[copy] + 1'b1;
						blk_top[copy]   = TOP_W'(need);
						rsp.status = ST_OK;
						rsp.handle = IDX_W'(slot);
						rsp.offset = blk_tab[copy][slot].start + SIZE_W'(HEADER_BYTES);
						rsp.bytes  = rq.size;
					end
				end
			end
		end else if (32'(rq.hnd) >= 32'(blk_count[copy])) begin
			rsp.status = ST_BAD_HANDLE;
			rsp.handle = rq.hnd;
		end else begin
			// The result describes the block as it was; the top block leaves the
			// table and takes the heap top down with it, any other is marked free.
			rsp.status = ST_OK;
			rsp.handle = rq.hnd;
			rsp.offset = blk_tab[copy][rq.hnd].start + SIZE_W'(HEADER_BYTES);
			rsp.bytes  = blk_tab[copy][rq.hnd].size;
			if (32'(rq.hnd) + 1 == 32'(blk_count[copy])) begin
				blk_count[copy] = CNT_W'(rq.hnd);
				blk_top[copy]   = TOP_W'(blk_tab[copy][rq.hnd].start);
			end else begin
				blk_tab[copy][rq.hnd].free = 1'b1;
			end
		end
		rsp.used = blk_top[copy];
		return rsp;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
			mismatch_count++;
		end
	endfunction

	// Requested sizes: mostly within the chosen mix, with some zero sizes, some
	// fully random words and the largest size mixed in.
	function automatic logic [SIZE_W-1:0] pick_size(size_mix_t mix);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return '0;
		if (roll < 8)
			return SIZE_W'($urandom);
		if (roll < 9)
			return '1;
		case (mix)
			SZ_TINY: return SIZE_W'($urandom_range(64, 1));
			SZ_MID:  return SIZE_W'($urandom_range(4096, 1));
			default: return SIZE_W'($urandom_range(262143, 1024));
		endcase
	endfunction

	// Frees mostly name a block that exists, often the top one; the rest are
	// random handles, many of them bad.
	function automatic logic [IDX_W-1:0] pick_handle();
		int unsigned cnt;
		int unsigned roll;
		cnt  = 32'(blk_count[STEER_COPY]);
		roll = $urandom_range(99);
		if (cnt == 0 || roll < 10)
			return IDX_W'($urandom);
		if (roll < 45)
			return IDX_W'(cnt - 1);
		return IDX_W'($urandom_range(cnt - 1));
	endfunction

	task automatic queue_req(logic k, logic [SIZE_W-1:0] s, logic [IDX_W-1:0] h);
		alloc_req_t rq;
		rq = {k, s, h};
		pending_requests.push_back(rq);
		void'(serve_request(STEER_COPY, rq));
	endtask

	// Unused fields carry random noise so that the block is seen to ignore them.
	task automatic queue_random(int p_alloc, size_mix_t mix);
		if ($urandom_range(99) < p_alloc)
			queue_req(KIND_ALLOC, pick_size(mix), IDX_W'($urandom));
		else
			queue_req(KIND_FREE, SIZE_W'($urandom), pick_handle());
	endtask

	// Frees the top block until the table is empty.
	task automatic queue_teardown();
		while (blk_count[STEER_COPY] != '0)
			queue_req(KIND_FREE, SIZE_W'($urandom), IDX_W'(blk_count[STEER_COPY] - 1'b1));
	endtask

	// Waits until every queued request has been taken and every result has
	// come back, then lets the block settle.
	task automatic wait_idle();
		while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_mix(int count, int p_alloc, size_mix_t mix);
		repeat (count) queue_random(p_alloc, mix);
		wait_idle();
	endtask

	task automatic check_heap_limit(logic [TOP_W-1:0] exp_val);
		logic [PDATA_W-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(4 * int'(REG_HEAP_LIMIT));
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_field("heap_limit readback", 32'(exp_val), 32'(got));
	endtask

	// Only called while the block is idle. Bits above the register width are
	// dropped by the block.
	task automatic write_heap_limit(logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(REG_HEAP_LIMIT));
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		limit_bytes = value[TOP_W-1:0];
		check_heap_limit(limit_bytes);
	endtask

	// Request driver: a payload is held until its transaction completes, then
	// the next one is presented, unless an idle burst is under way.
	always @(negedge clk) begin
		if (req_valid && !req_fire) begin
			// Stalled: hold the payload as it is.
		end else if (send_gap > 0) begin
			req_valid <= 1'b0;
			send_gap = send_gap - 1;
		end else if (!steady_tail && $urandom_range(5) == 0) begin
			req_valid <= 1'b0;
			send_gap = $urandom_range(2);
		end else if (pending_requests.size() != 0) begin
			next_req = pending_requests.pop_front();
			req_valid    <= 1'b1;
			kind         <= next_req.kind;
			req_size     <= next_req.size;
			block_handle <= next_req.hnd;
		end else begin
			req_valid <= 1'b0;
		end
	end

	// Response side: stalls in random bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (!steady_tail && $urandom_range(4) == 0) begin
			rsp_stall <= 1'b1;
			stall_left = $urandom_range(2);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Monitor: each response transaction is checked against the oldest
	// prediction, and each request transaction adds a new one. A result can
	// never come back in the cycle its request is taken, so the order of the
	// two steps does not matter.
	always @(posedge clk) begin
		req_fire = arst_n && req_valid && !req_stall;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d handle %0d",
					$time, status, handle);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("handle", 32'(want.handle), 32'(handle));
				check_field("payload_offset", 32'(want.offset), 32'(payload_offset));
				check_field("block_bytes", 32'(want.bytes), 32'(block_bytes));
				check_field("heap_used", 32'(want.used), 32'(heap_used));
			end
		end
		if (req_fire)
			expected_results.push_back(serve_request(CHECK_COPY,
				alloc_req_t'({kind, req_size, block_handle})));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < 2; c++) begin
			blk_count[c] = '0;
			blk_top[c]   = '0;
		end
		limit_bytes = LIMIT_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_heap_limit(LIMIT_RESET);

		// Directed opening under the reset limit: zero size, bad handles on an
		// empty table, a request too large for the heap, a double free, first
		// fit reuse, top removal and an allocation that fills the heap exactly.
		queue_req(KIND_ALLOC, '0, '0);
		queue_req(KIND_FREE, '0, '0);
		queue_req(KIND_FREE, '1, '1);
		queue_req(KIND_ALLOC, '1, '1);
		queue_req(KIND_ALLOC, 20'd100, '0);
		queue_req(KIND_ALLOC, 20'd200, '0);
		queue_req(KIND_ALLOC, 20'd50, '0);
		queue_req(KIND_FREE, '0, 6'd0);
		queue_req(KIND_FREE, '0, 6'd0);
		queue_req(KIND_ALLOC, 20'd300, '0);
		queue_req(KIND_ALLOC, 20'd80, '0);
		queue_req(KIND_FREE, '0, 6'd3);
		queue_req(KIND_FREE, '0, 6'd2);
		queue_req(KIND_FREE, '0, 6'd2);
		queue_req(KIND_ALLOC,
			SIZE_W'(32'(LIMIT_RESET) - 32'(blk_top[STEER_COPY]) - HEADER_BYTES), '0);
		queue_req(KIND_ALLOC, 20'd1, '0);
		queue_req(KIND_FREE, '0, 6'd2);
		queue_req(KIND_ALLOC, 20'd1, '0);
		queue_req(KIND_FREE, '0, 6'd0);
		queue_req(KIND_ALLOC, 20'd100, '0);
		wait_idle();

		run_mix(200, 60, SZ_MID);

		// A zero limit refuses every append; frees still work.
		write_heap_limit('0);
		run_mix(30, 50, SZ_TINY);

		// Limit above the cap, with junk above the register width: small
		// allocations fill the table until it reports full.
		write_heap_limit(32'hA5E0_0000 | 32'h001F_FFFF);
		queue_teardown();
		run_mix(200, 85, SZ_TINY);

		// Limit exactly at the cap, large blocks so that the heap runs out.
		write_heap_limit(32'(LIMIT_CAP));
		queue_teardown();
		run_mix(200, 55, SZ_BIG);

		repeat (3) begin
			write_heap_limit(32'($urandom_range(1200000)));
			run_mix(100, 60, SZ_MID);
		end

		// Last stretch back at the reset limit, with no idling on either side.
		write_heap_limit(32'(LIMIT_RESET));
		steady_tail = 1'b1;
		run_mix(150, 60, SZ_TINY);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
tb/sv/tb_top.sv
